// File: rtl/mck_pkg.sv
// Shared types, constants and Morse code tables for the character keyer.
package mck_pkg;

    localparam int MaxElems   = 5;
    localparam int QueueDepth = 2;

    localparam logic [7:0] SpaceChar = 8'h20;
    localparam logic [7:0] UpperA    = 8'h41;
    localparam logic [7:0] UpperZ    = 8'h5A;
    localparam logic [7:0] LowerA    = 8'h61;
    localparam logic [7:0] LowerZ    = 8'h7A;
    localparam logic [7:0] Digit0    = 8'h30;
    localparam logic [7:0] Digit9    = 8'h39;

    localparam logic [2:0] DurDot     = 3'd1;
    localparam logic [2:0] DurDash    = 3'd3;
    localparam logic [2:0] DurElemGap = 3'd1;
    localparam logic [2:0] DurCharGap = 3'd3;
    localparam logic [2:0] DurWordGap = 3'd7;

    // Nibble per element, first element in the highest used nibble: 1 dot, 2 dash.
    localparam logic [19:0] LetterCodes [26] = '{
        20'h00012, 20'h02111, 20'h02121, 20'h00211, 20'h00001, 20'h01121, 20'h00221,
        20'h01111, 20'h00011, 20'h01222, 20'h00212, 20'h01211, 20'h00022, 20'h00021,
        20'h00222, 20'h01221, 20'h02212, 20'h00121, 20'h00111, 20'h00002, 20'h00112,
        20'h01112, 20'h00122, 20'h02112, 20'h02122, 20'h02211
    };

    localparam logic [19:0] DigitCodes [10] = '{
        20'h22222, 20'h12222, 20'h11222, 20'h11122, 20'h11112,
        20'h11111, 20'h21111, 20'h22111, 20'h22211, 20'h22221
    };

    // Character descriptor handed from front to back; dashes[0] is the first element.
    typedef struct packed {
        logic       is_space;
        logic [2:0] count;
        logic [4:0] dashes;
    } mck_desc_t;

    typedef struct packed {
        logic      valid;
        mck_desc_t desc;
    } mck_head_t;

endpackage

// File: rtl/mck_front.sv
// Front end: accepts characters, classifies them and writes descriptors into the queue.
module mck_front (
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        char_code,
    input  logic              queue_full,
    output logic              push,
    output mck_pkg::mck_desc_t push_desc
);
    import mck_pkg::*;

    logic [7:0]  offset;
    logic [19:0] code;
    logic [2:0]  count;
    logic [4:0]  dashes;
    logic [2:0]  pos;

    always_comb
    begin
        offset = 8'd0;
        code   = 20'h0;
        if (char_code >= UpperA && char_code <= UpperZ)
        begin
            offset = char_code - UpperA;
            code   = LetterCodes[offset[4:0]];
        end
        else if (char_code >= LowerA && char_code <= LowerZ)
        begin
            offset = char_code - LowerA;
            code   = LetterCodes[offset[4:0]];
        end
        else if (char_code >= Digit0 && char_code <= Digit9)
        begin
            offset = char_code - Digit0;
            code   = DigitCodes[offset[3:0]];
        end
    end

    // Codes have no inner gaps, so the element count is the number of used nibbles.
    always_comb
    begin
        count = 3'd0;
        for (int i = 0; i < MaxElems; i++)
        begin
            if (code[4*i +: 2] != 2'd0)
                count = count + 3'd1;
        end
        dashes = 5'd0;
        for (int i = 0; i < MaxElems; i++)
        begin
            if (3'(i) < count)
            begin
                pos       = count - 3'd1 - 3'(i);
                dashes[i] = code[4*pos + 1];
            end
        end
        pos = 3'd0;
    end

    assign in_stall           = queue_full;
    assign push               = in_valid && !queue_full;
    assign push_desc.is_space = (char_code == SpaceChar);
    assign push_desc.count    = count;
    assign push_desc.dashes   = dashes;

endmodule

// File: rtl/mck_queue.sv
// Short descriptor queue between the front and back ends.
module mck_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mck_pkg::mck_desc_t push_desc,
    output logic               full,
    input  logic               pop,
    output mck_pkg::mck_head_t head
);
    import mck_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    mck_desc_t        mem [QueueDepth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]    fill_reg, fill_next;

    assign full       = (fill_reg == (PtrW+1)'(QueueDepth));
    assign head.valid = (fill_reg != '0);
    assign head.desc  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_desc;
    end

endmodule

// File: rtl/mck_back.sv
// Back end: steps through a descriptor and emits one keying segment per cycle while the output is not stalled.
module mck_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mck_pkg::mck_head_t head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               lamp_on,
    output logic [2:0]         duration_units,
    output logic               last_segment
);
    import mck_pkg::*;

    logic       busy_reg, busy_next;
    mck_desc_t  cur_reg;
    logic [2:0] idx_reg, idx_next;
    logic       phase_reg, phase_next;
    logic       out_valid_reg, out_valid_next;
    logic       lamp_reg, lamp_next;
    logic [2:0] dur_reg, dur_next;
    logic       last_reg, last_next;

    mck_desc_t  src;
    logic [2:0] idx;
    logic       phase;
    logic       load;
    logic       fire;

    assign load  = !out_valid_reg || !out_stall;
    assign fire  = load && (busy_reg || head.valid);
    assign pop   = fire && !busy_reg;
    assign src   = busy_reg ? cur_reg : head.desc;
    assign idx   = busy_reg ? idx_reg : 3'd0;
    assign phase = busy_reg ? phase_reg : 1'b0;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        out_valid_next = load ? fire : out_valid_reg;
        lamp_next      = lamp_reg;
        dur_next       = dur_reg;
        last_next      = last_reg;
        if (fire)
        begin
            if (src.is_space)
            begin
                lamp_next = 1'b0;
                dur_next  = DurWordGap;
                last_next = 1'b1;
                busy_next = 1'b0;
            end
            else if (idx == src.count)
            begin
                lamp_next = 1'b0;
                dur_next  = DurCharGap;
                last_next = 1'b1;
                busy_next = 1'b0;
            end
            else if (!phase)
            begin
                lamp_next  = 1'b1;
                dur_next   = src.dashes[idx] ? DurDash : DurDot;
                last_next  = 1'b0;
                busy_next  = 1'b1;
                idx_next   = idx;
                phase_next = 1'b1;
            end
            else
            begin
                lamp_next  = 1'b0;
                dur_next   = DurElemGap;
                last_next  = 1'b0;
                busy_next  = 1'b1;
                idx_next   = idx + 3'd1;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 3'd0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head.desc;
        lamp_reg <= lamp_next;
        dur_reg  <= dur_next;
        last_reg <= last_next;
    end

    assign out_valid      = out_valid_reg;
    assign lamp_on        = lamp_reg;
    assign duration_units = dur_reg;
    assign last_segment   = last_reg;

endmodule

// File: rtl/morse_character_keyer.sv
// Top level of the Morse character keyer: front end, descriptor queue, segment generator.
//
// Input channel: in_valid / in_stall with char_code, one ASCII character per
// transaction. Output channel: out_valid / out_stall with lamp_on,
// duration_units and last_segment, one keying segment per transaction.
// A letter or digit of n elements gives 2n+1 segments (lit element, 1-unit
// gap, ..., closing 3-unit gap); a space gives one 7-unit dark segment; any
// other code gives one 3-unit dark segment. last_segment marks the end of a
// character.
// The front end classifies a character in the cycle it is taken and writes a
// descriptor into a two-entry queue; in_stall is high only while that queue
// is full. The back end emits one segment per cycle into an output register while
// the output is not stalled, so a character gives 1 to 11 segments (2n+1); its first
// segment passes through a queue entry and then the output register.
// While out_stall is high the output register holds its segment and the
// generator waits; the queue keeps taking characters until it fills.
// Reset empties the queue and the output register; nothing else needs clearing.
module morse_character_keyer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       lamp_on,
    output logic [2:0] duration_units,
    output logic       last_segment
);
    import mck_pkg::*;

    logic      push;
    logic      queue_full;
    logic      pop;
    mck_desc_t push_desc;
    mck_head_t head;

    mck_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    mck_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    mck_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .lamp_on        (lamp_on),
        .duration_units (duration_units),
        .last_segment   (last_segment)
    );

endmodule
